[hw/rtl/qph_pkg.sv]
// Shared types and constants of the quadratic probing hash table.
package qph_pkg;

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_UPSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH,
        ST_ISSUE,
        ST_CHECK,
        ST_CLEAR,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        used;
        logic [31:0] key;
        logic [31:0] value;
    } t_slot;

    typedef struct packed {
        logic start;
        logic step;
    } t_probe_ctl;

endpackage

[hw/rtl/qph_mod_unit.sv]
// Pipelined unit that reduces a signed key to its non-negative home slot by reciprocal multiplication.
module qph_mod_unit #(
    parameter int  TABLE_SIZE = 1031,
    localparam int IW         = $clog2(TABLE_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_key,
    output logic          o_done,
    output logic [IW-1:0] o_home
);

    localparam int          SHIFT = 31 + IW;
    localparam logic [IW:0] MOD_N = (IW+1)'(TABLE_SIZE);
    localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(TABLE_SIZE));

    logic [2:0]    r_pipe;
    logic          r_done;
    logic [31:0]   r_mag;
    logic          r_neg;
    logic [31:0]   r_q;
    logic [IW:0]   r_rem;
    logic [IW-1:0] r_home;
    logic [31:0]   n_q;
    logic [IW:0]   n_rem;
    logic [IW-1:0] n_home;

    // The estimated quotient is low by at most one, so one compare and subtract finishes it.
    always_comb begin
        logic [63:0] prod;
        logic [63:0] back;
        logic [IW:0] rem_t;
        prod  = {32'd0, r_mag} * {32'd0, RECIP};
        n_q   = 32'(prod >> SHIFT);
        back  = {32'd0, r_q} * 64'(TABLE_SIZE);
        n_rem = r_mag[IW:0] - back[IW:0];
        rem_t = r_rem;
        if (rem_t >= MOD_N) begin
            rem_t = rem_t - MOD_N;
        end
        if (r_neg && (rem_t != '0)) begin
            n_home = IW'(MOD_N - rem_t);
        end else begin
            n_home = rem_t[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe <= '0;
            r_done <= 1'b0;
        end else begin
            r_pipe <= {r_pipe[1:0], i_start};
            r_done <= r_pipe[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_key[31];
            r_mag <= i_key[31] ? (32'd0 - i_key) : i_key;
        end
        if (r_pipe[0]) begin
            r_q <= n_q;
        end
        if (r_pipe[1]) begin
            r_rem <= n_rem;
        end
        if (r_pipe[2]) begin
            r_home <= n_home;
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

[hw/rtl/qph_probe_gen.sv]
// Probe address generator that walks the quadratic sequence without multiplying.
module qph_probe_gen #(
    parameter int  TABLE_SIZE = 1031,
    parameter int  MAX_ROUNDS = 64,
    localparam int IW         = $clog2(TABLE_SIZE),
    localparam int RW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qph_pkg::t_probe_ctl   i_ctl,
    input  logic [IW-1:0]         i_home,
    output logic [IW-1:0]         o_idx,
    output logic                  o_last
);

    localparam logic [IW:0]   MOD_N = (IW+1)'(TABLE_SIZE);
    localparam logic [IW-1:0] SQ1   = IW'(1 % TABLE_SIZE);
    localparam logic [IW-1:0] ODD1  = IW'(3 % TABLE_SIZE);
    localparam logic [IW-1:0] TWO   = IW'(2 % TABLE_SIZE);

    logic [IW-1:0] r_sq;
    logic [IW-1:0] r_odd;
    logic [RW-1:0] r_round;
    logic          r_side;
    logic [IW-1:0] n_sq;
    logic [IW-1:0] n_odd;
    logic [IW-1:0] left_idx;
    logic [IW-1:0] right_idx;

    always_comb begin
        logic [IW:0] s_sq;
        logic [IW:0] s_odd;
        logic [IW:0] s_left;
        logic [IW:0] s_right;
        s_sq = {1'b0, r_sq} + {1'b0, r_odd};
        if (s_sq >= MOD_N) begin
            s_sq = s_sq - MOD_N;
        end
        s_odd = {1'b0, r_odd} + {1'b0, TWO};
        if (s_odd >= MOD_N) begin
            s_odd = s_odd - MOD_N;
        end
        s_left = {1'b0, i_home} + MOD_N - {1'b0, r_sq};
        if (s_left >= MOD_N) begin
            s_left = s_left - MOD_N;
        end
        s_right = {1'b0, i_home} + {1'b0, r_sq};
        if (s_right >= MOD_N) begin
            s_right = s_right - MOD_N;
        end
        n_sq      = s_sq[IW-1:0];
        n_odd     = s_odd[IW-1:0];
        left_idx  = s_left[IW-1:0];
        right_idx = s_right[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= 1'b0;
            r_round <= '0;
        end else if (i_ctl.start) begin
            r_side  <= 1'b0;
            r_round <= RW'(1);
        end else if (i_ctl.step) begin
            r_side <= ~r_side;
            if (r_side) begin
                r_round <= r_round + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sq  <= SQ1;
            r_odd <= ODD1;
        end else if (i_ctl.step && r_side) begin
            r_sq  <= n_sq;
            r_odd <= n_odd;
        end
    end

    assign o_idx  = r_side ? right_idx : left_idx;
    assign o_last = r_side && (r_round == RW'(MAX_ROUNDS));

endmodule

[hw/rtl/qph_store.sv]
// Slot memory holding the used flag, key and value of every table entry.
module qph_store #(
    parameter int  TABLE_SIZE = 1031,
    localparam int IW         = $clog2(TABLE_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IW-1:0]    i_rd_addr,
    output qph_pkg::t_slot   o_rd_data,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_addr,
    input  qph_pkg::t_slot   i_wr_data
);

    qph_pkg::t_slot r_mem [TABLE_SIZE];
    qph_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/quadratic_probe_hash_table.sv]
// Top level of the quadratic probing hash table with its operation sequencer.
//
// Usage: one operation enters per transfer on the s_axis channel; each operation
// gives exactly one result transfer on the m_axis channel. Modes are find,
// upsert and clear; an unused mode answers zeros and changes nothing.
// A find or upsert reduces the key to its home slot through registered steps
// (a reciprocal multiplication, a multiply-back and a correction), then reads
// one probe slot per cycle from the slot memory, which sets the pace. It makes
// 1 to 2 * MAX_ROUNDS probes; the next input can be taken in the cycle after
// the result is registered. A clear sweeps the memory one slot a cycle.
// After reset the same sweep empties the table while s_axis_tready stays low.
// Probe reads and writes never overlap, so the memory needs no forwarding.
// The result sits in an output register: a new operation is accepted while it
// waits, and a finished operation holds until the receiver takes the old one.
module quadratic_probe_hash_table #(
    parameter int TABLE_SIZE = 1031,
    parameter int MAX_ROUNDS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // mode[1:0], key[33:2], new_value[65:34], default_value[97:66], zero fill
    input  logic [qph_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // found[0], read_value[32:1], status[33], zero fill
    output logic [qph_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int IW = $clog2(TABLE_SIZE);

    qph_pkg::t_state     r_state;
    qph_pkg::t_state     n_state;
    logic [1:0]          r_mode;
    logic [31:0]         r_key;
    logic [31:0]         r_new;
    logic [31:0]         r_dflt;
    logic                r_found;
    logic [31:0]         r_value;
    logic                r_status;
    logic [IW-1:0]       r_chk_idx;
    logic                r_chk_last;
    logic [IW-1:0]       r_sweep;
    logic                r_ovalid;
    logic [qph_pkg::OUT_TDATA_W-1:0] r_odata;

    logic                accept;
    logic [1:0]          acc_mode;
    logic                acc_probe;
    logic                mod_start;
    logic                mod_done;
    logic [IW-1:0]       home;
    qph_pkg::t_probe_ctl probe_ctl;
    logic [IW-1:0]       probe_idx;
    logic                probe_last;
    logic                issue;
    logic                hit;
    logic                sweep_end;
    logic                load_out;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    qph_pkg::t_slot      wr_data;
    qph_pkg::t_slot      rd_data;

    assign acc_mode  = s_axis_tdata[1:0];
    assign acc_probe = (acc_mode == qph_pkg::MODE_FIND) || (acc_mode == qph_pkg::MODE_UPSERT);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign hit       = !rd_data.used || (rd_data.key == r_key);
    assign sweep_end = (r_sweep == IW'(TABLE_SIZE - 1));

    qph_mod_unit #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (s_axis_tdata[33:2]),
        .o_done  (mod_done),
        .o_home  (home)
    );

    qph_probe_gen #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_probe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (probe_ctl),
        .i_home  (home),
        .o_idx   (probe_idx),
        .o_last  (probe_last)
    );

    qph_store #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (issue),
        .i_rd_addr (probe_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qph_pkg::ST_INIT: begin
                if (sweep_end) begin
                    n_state = qph_pkg::ST_IDLE;
                end
            end
            qph_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (acc_mode) inside
                        qph_pkg::MODE_FIND, qph_pkg::MODE_UPSERT: n_state = qph_pkg::ST_HASH;
                        qph_pkg::MODE_CLEAR: n_state = qph_pkg::ST_CLEAR;
                        default: n_state = qph_pkg::ST_OUT;
                    endcase
                end
            end
            qph_pkg::ST_HASH: begin
                if (mod_done) begin
                    n_state = qph_pkg::ST_ISSUE;
                end
            end
            qph_pkg::ST_ISSUE: begin
                n_state = qph_pkg::ST_CHECK;
            end
            qph_pkg::ST_CHECK: begin
                if (hit || r_chk_last) begin
                    n_state = qph_pkg::ST_OUT;
                end
            end
            qph_pkg::ST_CLEAR: begin
                if (sweep_end) begin
                    n_state = qph_pkg::ST_OUT;
                end
            end
            qph_pkg::ST_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = qph_pkg::ST_IDLE;
                end
            end
            default: n_state = qph_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        s_axis_tready   = (r_state == qph_pkg::ST_IDLE);
        mod_start       = accept && acc_probe;
        issue           = (r_state == qph_pkg::ST_ISSUE) ||
                          ((r_state == qph_pkg::ST_CHECK) && !hit && !r_chk_last);
        probe_ctl.start = mod_done;
        probe_ctl.step  = issue;
        load_out        = (r_state == qph_pkg::ST_OUT) && (!r_ovalid || m_axis_tready);
        wr_en           = 1'b0;
        wr_addr         = r_sweep;
        wr_data         = '0;
        if ((r_state == qph_pkg::ST_INIT) || (r_state == qph_pkg::ST_CLEAR)) begin
            wr_en = 1'b1;
        end else if ((r_state == qph_pkg::ST_CHECK) && hit &&
                     (r_mode == qph_pkg::MODE_UPSERT)) begin
            wr_en         = 1'b1;
            wr_addr       = r_chk_idx;
            wr_data.used  = 1'b1;
            wr_data.key   = r_key;
            wr_data.value = r_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qph_pkg::ST_INIT;
            r_sweep  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en && ((r_state == qph_pkg::ST_INIT) || (r_state == qph_pkg::ST_CLEAR))) begin
                r_sweep <= sweep_end ? '0 : (r_sweep + IW'(1));
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= acc_mode;
            r_key    <= s_axis_tdata[33:2];
            r_new    <= s_axis_tdata[65:34];
            r_dflt   <= s_axis_tdata[97:66];
            r_found  <= 1'b0;
            r_status <= 1'b0;
            r_value  <= acc_probe ? s_axis_tdata[97:66] : 32'd0;
        end
        if (issue) begin
            r_chk_idx  <= probe_idx;
            r_chk_last <= probe_last;
        end
        if (r_state == qph_pkg::ST_CHECK) begin
            if (hit) begin
                r_found <= rd_data.used;
                r_value <= rd_data.used ? rd_data.value : r_dflt;
            end else if (r_chk_last) begin
                r_status <= 1'b1;
            end
        end
        if (load_out) begin
            r_odata <= {6'd0, r_status, r_value, r_found};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef SYNTHESIS
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(issue && wr_en))
        else $error("Slot memory read and write in the same cycle.");

    a_probe_write_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (r_state == qph_pkg::ST_CHECK)) |-> (hit && (r_mode == qph_pkg::MODE_UPSERT)))
        else $error("Slot written without a free or matching slot.");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qph_pkg::ST_CHECK) |-> (32'(r_chk_idx) < 32'(TABLE_SIZE)))
        else $error("Probe slot outside the table.");

    a_hash_done_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == qph_pkg::ST_HASH))
        else $error("Home slot ready outside the hash phase.");

    a_one_op_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("Second operation taken before the first one finished.");
`endif

endmodule
